FILE: rtl/core/acz_pkg.sv
// ----------------------------------------------------------------------------
// acz_pkg
// Shared types, constants and the response curve table for the bender
// auto-zero curve shaper.
// ----------------------------------------------------------------------------
package acz_pkg;

    // curve table geometry
    localparam int CURVE_POINTS  = 33;
    localparam int FRACTION_BITS = 6;
    localparam int ROM_DEPTH     = 3 * CURVE_POINTS;
    localparam int ROM_AW        = $clog2(ROM_DEPTH);
    localparam int CURVE_N       = CURVE_POINTS - 1;
    localparam longint CURVE_N3  = longint'(CURVE_N) * CURVE_N * CURVE_N;

    // datapath widths
    localparam int RAW_W    = 12;
    localparam int OFFSET_W = 13;
    localparam int MAG_W    = 12;
    localparam int GAIN_W   = 13;
    localparam int PROD_W   = MAG_W + GAIN_W;
    localparam int SHAPE_W  = 13;
    localparam int BEND_W   = 14;
    localparam int SCALED_W = 11;
    localparam int IDX_W    = SCALED_W - FRACTION_BITS;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 13;

    // fixed values
    localparam int CLIP_LIMIT                    = 2047 * 4096;
    localparam logic [BEND_W-1:0]  CENTRE        = 14'd8000;
    localparam logic [SHAPE_W-1:0] SHAPE_FULL    = 13'd8000;
    localparam logic signed [OFFSET_W-1:0] ZERO_RESET = 13'sd2048;

    // output queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_CURVE_SELECT    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_DEAD_RANGE      = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_SMALL_THRESHOLD = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_TEST_PERIOD     = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_RAMP_STEP       = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_GAIN_FACTOR     = 3'd5;

    localparam logic [1:0] CURVE_SEL_INVALID = 2'd3;

    typedef struct packed {
        logic [1:0]         curve_select;
        logic [7:0]         dead_range;
        logic [10:0]        small_threshold;
        logic [7:0]         test_period;
        logic [7:0]         ramp_step;
        logic [GAIN_W-1:0]  gain_factor;
    } t_cfg;

    typedef enum logic [1:0] {
        JOB_CENTRE = 2'd0,
        JOB_UP     = 2'd1,
        JOB_DOWN   = 2'd2
    } t_job_kind;

    typedef struct packed {
        t_job_kind          kind;
        logic [MAG_W-1:0]   mag;
    } t_job;

    // table entry g: curve g / CURVE_POINTS at point g % CURVE_POINTS
    function automatic logic [SHAPE_W-1:0] curve_entry(input int g);
        longint crv;
        longint pt;
        longint val;
        crv = longint'(g / CURVE_POINTS);
        pt  = longint'(g % CURVE_POINTS);
        case (crv)
            0:       val = (8000 * pt) / CURVE_N;
            1:       val = (4000 * (pt * CURVE_N * CURVE_N + pt * pt * pt)) / CURVE_N3;
            default: val = (8000 * pt * pt * pt) / CURVE_N3;
        endcase
        return val[SHAPE_W-1:0];
    endfunction

endpackage

FILE: rtl/core/acz_queue.sv
// ----------------------------------------------------------------------------
// acz_queue
// Short job queue between the auto-zero front and the shaping back.
// ----------------------------------------------------------------------------
module acz_queue import acz_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_head,
    output logic o_empty
);

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job              r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slots[r_rd_ptr];

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/core/acz_front.sv
// ----------------------------------------------------------------------------
// acz_front
// Takes raw samples, tracks the zero point with drift test and ramp, and
// classifies each changed offset into a shaping job.
// ----------------------------------------------------------------------------
module acz_front import acz_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [RAW_W-1:0] i_raw_sample,
    input  t_cfg             i_cfg,
    output logic             o_push,
    output t_job             o_push_job,
    input  logic             i_queue_full
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_EVAL = 3'b010,
        F_PUSH = 3'b100
    } t_front_state;

    t_front_state                r_state;
    logic signed [OFFSET_W-1:0]  r_value;
    logic signed [OFFSET_W-1:0]  r_zero_point;
    logic signed [OFFSET_W-1:0]  r_prev_offset;
    logic                        r_small_flag;
    logic                        r_test_active;
    logic [7:0]                  r_test_count;
    logic                        r_ramp_active;
    logic signed [OFFSET_W-1:0]  r_ramp_left;
    logic                        r_ramp_up;
    t_job                        r_job;

    logic signed [OFFSET_W-1:0]  n_zero_point;
    logic                        n_small_flag;
    logic                        n_test_active;
    logic [7:0]                  n_test_count;
    logic                        n_ramp_active;
    logic signed [OFFSET_W-1:0]  n_ramp_left;
    logic                        n_ramp_up;
    t_job                        n_job;

    logic signed [OFFSET_W-1:0]  w_thr;
    logic signed [OFFSET_W-1:0]  w_dr;
    logic signed [OFFSET_W-1:0]  w_step;
    logic signed [OFFSET_W-1:0]  w_left;
    logic                        w_small;
    logic                        w_emit;

    assign o_in_stall = (r_state != F_IDLE);
    assign o_push     = (r_state == F_PUSH) && !i_queue_full;
    assign o_push_job = r_job;

    assign w_thr  = signed'({2'b00, i_cfg.small_threshold});
    assign w_dr   = signed'({5'b00000, i_cfg.dead_range});
    assign w_step = signed'({5'b00000, i_cfg.ramp_step});

    // drift test and zero ramp update
    always_comb begin
        n_zero_point  = r_zero_point;
        n_test_active = r_test_active;
        n_test_count  = r_test_count;
        n_ramp_active = r_ramp_active;
        n_ramp_left   = r_ramp_left;
        n_ramp_up     = r_ramp_up;

        w_small      = (r_value > -w_thr) && (r_value < w_thr);
        n_small_flag = w_small;
        if (w_small) begin
            if (!r_small_flag) begin
                n_test_count  = '0;
                n_test_active = 1'b1;
            end
        end else if (r_small_flag) begin
            n_test_active = 1'b0;
        end

        if (n_test_active) begin
            if (n_test_count < i_cfg.test_period) begin
                n_test_count = n_test_count + 8'd1;
            end else begin
                n_test_active = 1'b0;
                n_ramp_active = 1'b1;
                if (r_value > 0) begin
                    n_ramp_left = r_value;
                    n_ramp_up   = 1'b1;
                end else begin
                    n_ramp_left = -r_value;
                    n_ramp_up   = 1'b0;
                end
            end
        end

        w_left = n_ramp_left - w_step;
        if (n_ramp_active) begin
            if (w_left <= 0) begin
                n_ramp_active = 1'b0;
                n_ramp_left   = '0;
            end else begin
                n_ramp_left  = w_left;
                n_zero_point = n_ramp_up ? r_zero_point + w_step : r_zero_point - w_step;
            end
        end
    end

    // job classification of the offset
    always_comb begin
        n_job.kind = JOB_CENTRE;
        n_job.mag  = '0;
        w_emit     = 1'b0;
        if (r_value != r_prev_offset) begin
            if (r_value > w_dr) begin
                n_job.kind = JOB_UP;
                n_job.mag  = MAG_W'(r_value - w_dr);
                w_emit     = 1'b1;
            end else if (r_value < -w_dr) begin
                n_job.kind = JOB_DOWN;
                n_job.mag  = MAG_W'(-w_dr - r_value);
                w_emit     = 1'b1;
            end else if ((r_prev_offset > w_dr) || (r_prev_offset < -w_dr)) begin
                w_emit     = 1'b1;
            end
        end
    end

    // sample offset and job registers
    always_ff @(posedge i_clk) begin
        if ((r_state == F_IDLE) && i_in_valid) begin
            r_value <= signed'({1'b0, i_raw_sample}) - r_zero_point;
        end
        if (r_state == F_EVAL) begin
            r_job <= n_job;
        end
    end

    // sequencer and tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= F_IDLE;
            r_zero_point  <= ZERO_RESET;
            r_prev_offset <= '0;
            r_small_flag  <= 1'b0;
            r_test_active <= 1'b0;
            r_test_count  <= '0;
            r_ramp_active <= 1'b0;
            r_ramp_left   <= '0;
            r_ramp_up     <= 1'b0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= F_EVAL;
                    end
                end
                F_EVAL: begin
                    r_zero_point  <= n_zero_point;
                    r_prev_offset <= r_value;
                    r_small_flag  <= n_small_flag;
                    r_test_active <= n_test_active;
                    r_test_count  <= n_test_count;
                    r_ramp_active <= n_ramp_active;
                    r_ramp_left   <= n_ramp_left;
                    r_ramp_up     <= n_ramp_up;
                    r_state       <= w_emit ? F_PUSH : F_IDLE;
                end
                F_PUSH: begin
                    if (!i_queue_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/acz_back.sv
// ----------------------------------------------------------------------------
// acz_back
// Gain multiply, clip, curve interpolation and change filter on queued jobs;
// drives the result register.
// ----------------------------------------------------------------------------
module acz_back import acz_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_queue_empty,
    input  t_job              i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BEND_W-1:0] o_bend_value
);

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_LOOK  = 4'b0010,
        B_SHAPE = 4'b0100,
        B_EMIT  = 4'b1000
    } t_back_state;

    t_back_state                    r_state;
    t_job_kind                      r_kind;
    logic [PROD_W-1:0]              r_prod;
    logic [SHAPE_W-1:0]             r_lo;
    logic [SHAPE_W-1:0]             r_diff;
    logic [FRACTION_BITS-1:0]       r_frac;
    logic [BEND_W-1:0]              r_result;
    logic                           r_out_valid;
    logic [BEND_W-1:0]              r_bend_value;
    logic                           r_sent_valid;
    logic [BEND_W-1:0]              r_sent_value;

    logic [SHAPE_W-1:0]             w_rom [ROM_DEPTH];
    logic [SCALED_W-1:0]            w_scaled;
    logic [IDX_W-1:0]               w_idx;
    logic [FRACTION_BITS-1:0]       w_frac;
    logic                           w_clip;
    logic                           w_last;
    logic [ROM_AW-1:0]              w_base;
    logic [ROM_AW-1:0]              w_addr;
    logic [ROM_AW-1:0]              w_addr_next;
    logic [SHAPE_W+FRACTION_BITS-1:0] w_part;
    logic [SHAPE_W-1:0]             w_shape;
    logic [BEND_W-1:0]              n_result;
    logic                           w_same;
    logic                           w_out_free;
    logic                           w_load;

    // constant curve table
    for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
        assign w_rom[g] = curve_entry(g);
    end

    assign o_pop        = (r_state == B_IDLE) && !i_queue_empty;
    assign o_out_valid  = r_out_valid;
    assign o_bend_value = r_bend_value;

    // table address from scaled magnitude
    assign w_scaled    = r_prod[12 +: SCALED_W];
    assign w_idx       = w_scaled[SCALED_W-1:FRACTION_BITS];
    assign w_frac      = w_scaled[FRACTION_BITS-1:0];
    assign w_clip      = (r_prod > PROD_W'(CLIP_LIMIT));
    assign w_last      = (int'(w_idx) >= CURVE_POINTS - 1);
    assign w_base      = ROM_AW'(int'(i_cfg.curve_select) * CURVE_POINTS);
    assign w_addr      = w_base + (w_last ? ROM_AW'(CURVE_POINTS - 1) : ROM_AW'(w_idx));
    assign w_addr_next = w_last ? w_addr : w_addr + 1'b1;

    // interpolation between neighboring points
    assign w_part  = r_diff * r_frac;
    assign w_shape = r_lo + w_part[FRACTION_BITS +: SHAPE_W];

    always_comb begin
        case (r_kind)
            JOB_UP:   n_result = CENTRE + {1'b0, w_shape};
            JOB_DOWN: n_result = CENTRE - {1'b0, w_shape};
            default:  n_result = CENTRE;
        endcase
    end

    // change filter and output register handshake
    assign w_same     = r_sent_valid && (r_result == r_sent_value);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load     = (r_state == B_EMIT) && !w_same && w_out_free;

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_head.kind;
            r_prod <= PROD_W'(i_head.mag) * PROD_W'(i_cfg.gain_factor);
        end
        if (r_state == B_LOOK) begin
            if (w_clip) begin
                r_lo   <= SHAPE_FULL;
                r_diff <= '0;
                r_frac <= '0;
            end else begin
                r_lo   <= w_rom[w_addr];
                r_diff <= w_rom[w_addr_next] - w_rom[w_addr];
                r_frac <= w_frac;
            end
        end
        if (r_state == B_SHAPE) begin
            r_result <= n_result;
        end
        if (w_load) begin
            r_bend_value <= r_result;
            r_sent_value <= r_result;
        end
    end

    // sequencer, output valid and sent flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_out_valid  <= 1'b0;
            r_sent_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid  <= 1'b1;
                r_sent_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_queue_empty) begin
                        r_state <= B_LOOK;
                    end
                end
                B_LOOK: begin
                    r_state <= B_SHAPE;
                end
                B_SHAPE: begin
                    r_state <= B_EMIT;
                end
                B_EMIT: begin
                    if (w_same || w_out_free) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/bender_autozero_curve_shaper_core.sv
// ----------------------------------------------------------------------------
// bender_autozero_curve_shaper_core
// Bender auto-zero and response curve shaper: raw sample in, shaped bend
// position out, sent only when it changes.
//
//   channel | direction | handshake                 | beat
//   --------+-----------+---------------------------+-------------------------
//   in      | input     | i_in_valid / o_in_stall   | i_raw_sample (12 bit)
//   out     | output    | o_out_valid / i_out_stall | o_bend_value (14 bit)
//   cfg     | input     | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// The front registers a sample's offset, then does the tracking update and,
// for a sample that queues a job, the queue push; a sample that queues none
// skips the push. The back works through each job in turn (gain multiply,
// curve lookup, interpolation multiply, change filter) and takes the next
// job only when done with the last, also for one dropped by the change filter.
// Synchronous active-low reset clears all control state; no clearing pass.
// An output stall holds the back in its final step; the 2-entry job queue
// lets the front keep taking samples meanwhile.
// ----------------------------------------------------------------------------
module bender_autozero_curve_shaper_core import acz_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [RAW_W-1:0]  i_raw_sample,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BEND_W-1:0] o_bend_value,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic w_push;
    t_job w_push_job;
    logic w_queue_full;
    logic w_pop;
    t_job w_head;
    logic w_queue_empty;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.curve_select    <= 2'd1;
            r_cfg.dead_range      <= 8'd20;
            r_cfg.small_threshold <= 11'd200;
            r_cfg.test_period     <= 8'd80;
            r_cfg.ramp_step       <= 8'd8;
            r_cfg.gain_factor     <= 13'd4540;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CURVE_SELECT: begin
                    if (i_cfg_data[1:0] != CURVE_SEL_INVALID) begin
                        r_cfg.curve_select <= i_cfg_data[1:0];
                    end
                end
                CFG_DEAD_RANGE:      r_cfg.dead_range      <= i_cfg_data[7:0];
                CFG_SMALL_THRESHOLD: r_cfg.small_threshold <= i_cfg_data[10:0];
                CFG_TEST_PERIOD:     r_cfg.test_period     <= i_cfg_data[7:0];
                CFG_RAMP_STEP:       r_cfg.ramp_step       <= i_cfg_data[7:0];
                CFG_GAIN_FACTOR:     r_cfg.gain_factor     <= i_cfg_data[GAIN_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // auto-zero front
    acz_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_raw_sample (i_raw_sample),
        .i_cfg        (r_cfg),
        .o_push       (w_push),
        .o_push_job   (w_push_job),
        .i_queue_full (w_queue_full)
    );

    // job queue
    acz_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_job (w_push_job),
        .o_full     (w_queue_full),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_empty    (w_queue_empty)
    );

    // shaping back
    acz_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_queue_empty (w_queue_empty),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_bend_value  (o_bend_value)
    );

endmodule
